FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MWSG_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MWSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset
`define MWSG_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mwsg_pkg.sv
// ---------------------------------------------------------------------------
// mwsg_pkg
// Types, codes and the sine table function of the waveform sample generator.
// ---------------------------------------------------------------------------
package mwsg_pkg;

  // Default parameter values
  localparam int unsigned SINE_DEPTH_DEF  = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 20;

  // Depth of the request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Waveform modes
  typedef enum logic [2:0] {
    MODE_SQUARE   = 3'd0,
    MODE_PWM      = 3'd1,
    MODE_SINE     = 3'd2,
    MODE_PHASE    = 3'd3,
    MODE_TRIANGLE = 3'd4,
    MODE_SAW      = 3'd5,
    MODE_INV_SAW  = 3'd6,
    MODE_PRBS     = 3'd7
  } wave_mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WAVE_MODE  = 3'd0,
    CFG_AMPLITUDE  = 3'd1,
    CFG_PERIOD     = 3'd2,
    CFG_DUTY       = 3'd3,
    CFG_PHASE_STEP = 3'd4,
    CFG_RAMP_SLOPE = 3'd5
  } cfg_index_t;

  // Per-sample classification made by the front
  typedef struct packed {
    logic at_zero;     // count is 0
    logic at_half;     // count equals half period
    logic pwm_high;    // count is 0 and duty is non-zero
    logic at_duty;     // count equals duty
    logic below_half;  // count below half period
    logic below_duty;  // count below duty
  } flags_t;

  // Back sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_LOOK,
    BK_SCALE,
    BK_FIN
  } bk_state_t;

  // Back datapath controls
  typedef struct packed {
    logic start;
    logic load_prod;
    logic scale_sel;
    logic load_off;
    logic commit;
  } bk_ctl_t;

  // Odd Taylor coefficients of sin(pi/2*t), Q30
  localparam longint unsigned TAYLOR_Q30 [5] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272
  };
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // Quarter-wave entry r of a table of 2^log2d entries, Q15 magnitude.
  // Evaluated at elaboration only.
  function automatic logic [14:0] quarter_q15(input int unsigned r,
                                              input int unsigned log2d);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned p;
    longint unsigned q;
    t  = longint'(r) << (32 - log2d);
    t2 = (t * t) >> 30;
    p  = TAYLOR_Q30[4];
    p  = TAYLOR_Q30[3] - ((p * t2) >> 30);
    p  = TAYLOR_Q30[2] - ((p * t2) >> 30);
    p  = TAYLOR_Q30[1] - ((p * t2) >> 30);
    p  = TAYLOR_Q30[0] - ((p * t2) >> 30);
    p  = (p * t) >> 30;
    if (p > Q30_ONE) p = Q30_ONE;
    q  = (p * 64'd32767 + (64'd1 << 29)) >> 30;
    return q[14:0];
  endfunction

endpackage

FILE: sv/multi_waveform_sample_generator.sv
// ---------------------------------------------------------------------------
// multi_waveform_sample_generator
// Waveform synthesiser giving one DAC sample per running sample tick.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : sample ticks; in_tdata[0] is run. A tick with run low is taken
//           and dropped: no sample, no state change.
//   out_* : one 16-bit sample per tick with run high, in order.
//   cfg_* : register writes (mode, amplitude, period, duty, phase step,
//           ramp slope), only while no tick is in flight.
// Timing: the front classifies one tick per cycle into a two-entry request
//   queue while the queue has room. The back works through one request at
//   a time on one shared 32x32 multiplier: square, PWM and PRBS take the
//   finish step only, ramps the multiply and finish steps, sine and
//   phase-angle the phase multiply, table lookup, amplitude multiply and
//   finish steps.
// Stall: a held-off sample waits in the output register; the back stops
//   in its finish step and the queue fills, then in_tready drops.
// Reset: counter, held level and output valid clear, noise register goes to 1,
//   registers return to their defaults. No clearing pass; the sine table
//   is constant logic.
// ---------------------------------------------------------------------------
module multi_waveform_sample_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = mwsg_pkg::SINE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS      = mwsg_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS       = mwsg_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] run, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] dac_sample
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import mwsg_pkg::*;

  localparam int unsigned Q_W = COUNT_BITS + $bits(flags_t);

  wave_mode_t  wave_mode_r;
  logic [15:0] amplitude_r;
  logic [19:0] period_r;
  logic [19:0] duty_r;
  logic [31:0] phase_step_r;
  logic [31:0] ramp_slope_r;

  logic                  push_valid, push_ready;
  logic [COUNT_BITS-1:0] push_operand, pop_operand;
  flags_t                push_flags, pop_flags;
  logic                  pop_valid, pop_ready;
  logic [Q_W-1:0]        pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_mode_r  <= MODE_SQUARE;
      amplitude_r  <= '0;
      period_r     <= 20'd1;
      duty_r       <= '0;
      phase_step_r <= '0;
      ramp_slope_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAVE_MODE:  wave_mode_r  <= wave_mode_t'(cfg_wdata[2:0]);
        CFG_AMPLITUDE:  amplitude_r  <= cfg_wdata[15:0];
        CFG_PERIOD:     period_r     <= cfg_wdata[19:0];
        CFG_DUTY:       duty_r       <= cfg_wdata[19:0];
        CFG_PHASE_STEP: phase_step_r <= cfg_wdata;
        CFG_RAMP_SLOPE: ramp_slope_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  mwsg_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .wave_mode      (wave_mode_r),
    .period_samples (period_r),
    .duty_samples   (duty_r),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .run            (in_tdata[0]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_operand   (push_operand),
    .push_flags     (push_flags)
  );

  mwsg_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_flags, push_operand}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_operand = pop_data[COUNT_BITS-1:0];
  assign pop_flags   = flags_t'(pop_data[Q_W-1:COUNT_BITS]);

  mwsg_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .COUNT_BITS       (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wave_mode  (wave_mode_r),
    .amplitude  (amplitude_r),
    .phase_step (phase_step_r),
    .ramp_slope (ramp_slope_r),
    .q_valid    (pop_valid),
    .q_pop      (pop_ready),
    .q_operand  (pop_operand),
    .q_flags    (pop_flags),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sv/mwsg_queue.sv
// ---------------------------------------------------------------------------
// mwsg_queue
// Short register queue decoupling the front from the back.
// ---------------------------------------------------------------------------
module mwsg_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import mwsg_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_ready && pop_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: sv/mwsg_front.sv
// ---------------------------------------------------------------------------
// mwsg_front
// Accepts sample ticks, drops stopped ones, classifies the sample count and
// advances the wrapping counter.
// ---------------------------------------------------------------------------
module mwsg_front #(
  parameter int unsigned COUNT_BITS = mwsg_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mwsg_pkg::wave_mode_t  wave_mode,
  input  logic [19:0]           period_samples,
  input  logic [19:0]           duty_samples,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  run,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [COUNT_BITS-1:0] push_operand,
  output mwsg_pkg::flags_t      push_flags
);
  import mwsg_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > 20) ? COUNT_BITS : 20;

  logic [COUNT_BITS-1:0] sample_index_r, sample_index_nxt;
  logic [COUNT_BITS-1:0] index_inc;
  logic [CMP_W-1:0]      idx_w, half_w, duty_w, period_w;
  logic                  do_push;

  assign in_tready = push_ready;
  assign do_push   = in_tvalid && push_ready && run;
  assign push_valid = do_push;

  assign idx_w    = CMP_W'(sample_index_r);
  assign half_w   = CMP_W'(period_samples >> 1);
  assign duty_w   = CMP_W'(duty_samples);
  assign period_w = CMP_W'(period_samples);

  // Edge and region classification of the current count
  always_comb begin
    push_flags.at_zero    = (sample_index_r == '0);
    push_flags.at_half    = (idx_w == half_w);
    push_flags.pwm_high   = (sample_index_r == '0) && (duty_samples != '0);
    push_flags.at_duty    = (idx_w == duty_w);
    push_flags.below_half = (idx_w < half_w);
    push_flags.below_duty = (idx_w < duty_w);
  end

  // Multiplier operand: falling half of the triangle counts from half
  always_comb begin
    if (wave_mode == MODE_TRIANGLE && !(idx_w < half_w)) begin
      push_operand = COUNT_BITS'(idx_w - half_w);
    end else begin
      push_operand = sample_index_r;
    end
  end

  // Counter advance with wrap at the period
  assign index_inc = sample_index_r + COUNT_BITS'(1);
  always_comb begin
    sample_index_nxt = sample_index_r;
    if (do_push) begin
      sample_index_nxt = (CMP_W'(index_inc) >= period_w) ? '0 : index_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
    end else begin
      sample_index_r <= sample_index_nxt;
    end
  end

endmodule

FILE: sv/mwsg_back.sv
// ---------------------------------------------------------------------------
// mwsg_back
// Computes each queued sample over a shared multiplier and the quarter-wave
// sine table, updates the held level and noise register, and registers the
// result.
// ---------------------------------------------------------------------------
module mwsg_back #(
  parameter int unsigned SINE_TABLE_DEPTH = mwsg_pkg::SINE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS      = mwsg_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS       = mwsg_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mwsg_pkg::wave_mode_t  wave_mode,
  input  logic [15:0]           amplitude,
  input  logic [31:0]           phase_step,
  input  logic [31:0]           ramp_slope,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [COUNT_BITS-1:0] q_operand,
  input  mwsg_pkg::flags_t      q_flags,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata
);
  import mwsg_pkg::*;

  localparam int unsigned LOG2D = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QTR   = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QW    = LOG2D - 2;
  localparam logic [14:0] PEAK  = quarter_q15(QTR, LOG2D);
  localparam logic [15:0] SAMPLE_MAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam logic [15:0] OFFSET_MID = 16'h8000;

  bk_state_t             state_r, state_nxt, entry_state;
  bk_ctl_t               ctl;
  logic [COUNT_BITS-1:0] operand_r;
  flags_t                flags_r;
  logic [63:0]           prod_r;
  logic [15:0]           off_r, off_nxt;
  logic [15:0]           held_r, held_nxt;
  logic [30:0]           lfsr_r, lfsr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           out_data_r;

  logic [15:0]    amp_sat;
  logic           needs_mul, is_sine;
  logic [31:0]    mul_a, mul_b;
  logic [LOG2D-1:0] addr;
  logic [1:0]     quad;
  logic [QW-1:0]  qidx, qidx_mir;
  logic [14:0]    mag;
  logic [14:0]    qtab [QTR];
  logic [48:0]    sh_sel;
  logic [15:0]    term, diff;
  logic           fb;

  // Quarter-wave sine magnitudes, constant logic
  for (genvar g = 0; g < QTR; g++) begin : g_qtab
    assign qtab[g] = quarter_q15(g, LOG2D);
  end

  assign amp_sat   = (amplitude > SAMPLE_MAX) ? SAMPLE_MAX : amplitude;
  assign needs_mul = wave_mode inside {MODE_SINE, MODE_PHASE, MODE_TRIANGLE,
                                       MODE_SAW, MODE_INV_SAW};
  assign is_sine   = wave_mode inside {MODE_SINE, MODE_PHASE};
  assign entry_state = needs_mul ? BK_MUL : BK_FIN;

  // Sequencer outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      BK_IDLE:  ;
      BK_MUL:   ctl.load_prod = 1'b1;
      BK_LOOK:  ctl.load_off = 1'b1;
      BK_SCALE: begin
        ctl.load_prod = 1'b1;
        ctl.scale_sel = 1'b1;
      end
      BK_FIN:   ctl.commit = !out_valid_r || out_tready;
      default:  ;
    endcase
    ctl.start = q_valid && ((state_r == BK_IDLE) || ctl.commit);
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (ctl.start) state_nxt = entry_state;
      BK_MUL:   state_nxt = is_sine ? BK_LOOK : BK_FIN;
      BK_LOOK:  state_nxt = BK_SCALE;
      BK_SCALE: state_nxt = BK_FIN;
      BK_FIN: begin
        if (ctl.commit) state_nxt = ctl.start ? entry_state : BK_IDLE;
      end
      default:  state_nxt = BK_IDLE;
    endcase
  end

  assign q_pop = ctl.start;

  // Shared multiplier operands
  always_comb begin
    if (ctl.scale_sel) begin
      mul_a = 32'(off_r);
      mul_b = 32'(amp_sat >> 1);
    end else begin
      mul_a = 32'(operand_r);
      mul_b = is_sine ? phase_step : ramp_slope;
    end
  end

  // Table lookup from the phase word, with quarter-wave folding
  assign addr     = prod_r[31 -: LOG2D];
  assign quad     = addr[LOG2D-1 -: 2];
  assign qidx     = addr[QW-1:0];
  assign qidx_mir = ~qidx + QW'(1);
  always_comb begin
    if (quad[0]) begin
      mag = (qidx == '0) ? PEAK : qtab[qidx_mir];
    end else begin
      mag = qtab[qidx];
    end
    off_nxt = quad[1] ? (OFFSET_MID - {1'b0, mag}) : (OFFSET_MID + {1'b0, mag});
  end

  // Saturated product term and its difference from the amplitude
  always_comb begin
    if (wave_mode == MODE_SAW || wave_mode == MODE_INV_SAW) begin
      sh_sel = {1'b0, prod_r[63:16]};
    end else begin
      sh_sel = prod_r[63:15];
    end
    term = (sh_sel > 49'(SAMPLE_MAX)) ? SAMPLE_MAX : sh_sel[15:0];
    diff = (term >= amp_sat) ? 16'd0 : amp_sat - term;
  end

  // Noise register step
  assign fb       = lfsr_r[30] ^ lfsr_r[27];
  assign lfsr_nxt = {lfsr_r[29:0], fb};

  // Sample level by mode
  always_comb begin
    held_nxt = held_r;
    case (wave_mode)
      MODE_SQUARE: begin
        if (flags_r.at_zero)      held_nxt = amp_sat;
        else if (flags_r.at_half) held_nxt = 16'd0;
      end
      MODE_PWM: begin
        if (flags_r.pwm_high)     held_nxt = amp_sat;
        else if (flags_r.at_duty) held_nxt = 16'd0;
      end
      MODE_SINE:     held_nxt = term;
      MODE_PHASE:    held_nxt = flags_r.below_duty ? 16'd0 : term;
      MODE_TRIANGLE: held_nxt = flags_r.below_half ? term : diff;
      MODE_SAW:      held_nxt = term;
      MODE_INV_SAW:  held_nxt = diff;
      MODE_PRBS:     held_nxt = fb ? amp_sat : 16'd0;
      default:       held_nxt = held_r;
    endcase
  end

  // Output register
  always_comb begin
    if (ctl.commit)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      lfsr_r      <= 31'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctl.commit) begin
        held_r <= held_nxt;
        if (wave_mode == MODE_PRBS) lfsr_r <= lfsr_nxt;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      operand_r <= q_operand;
      flags_r   <= q_flags;
    end
    if (ctl.load_prod) prod_r <= 64'(mul_a) * 64'(mul_b);
    if (ctl.load_off)  off_r <= off_nxt;
    if (ctl.commit)    out_data_r <= held_nxt;
  end

endmodule

FILE: sv/mwsg_checker.sv
// ---------------------------------------------------------------------------
// mwsg_checker
// Port-level checks of the waveform sample generator, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mwsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // Running requests taken but whose samples are not yet delivered;
  // the queue, the back and the output register hold four at most
  logic [2:0] pending_r, pending_nxt;
  logic       run_in, sample_out;

  assign run_in     = in_tvalid && in_tready && in_tdata[0];
  assign sample_out = out_tvalid && out_tready;

  always_comb begin
    pending_nxt = pending_r;
    if (run_in && !sample_out)      pending_nxt = pending_r + 3'd1;
    else if (sample_out && !run_in) pending_nxt = pending_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pending_r <= '0;
    else        pending_r <= pending_nxt;
  end

  `MWSG_ASSERT_ALWAYS(a_reset_empties_output, clk, !rst_n, !out_tvalid, "output valid after reset")
  `MWSG_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled sample changed")
  `MWSG_ASSERT(a_no_invented_sample, clk, rst_n, out_tvalid, pending_r != 3'd0, "sample without running request")
  `MWSG_ASSERT(a_capacity, clk, rst_n, 1'b1, pending_r <= 3'd4, "more requests in flight than storage")

endmodule

bind multi_waveform_sample_generator mwsg_checker u_mwsg_checker (.*);
